// ----- rtl/ccmq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ccmq_pkg;

  localparam int COEF_W      = 16;
  localparam int IDX_W       = 9;
  localparam int MOD_W       = 16;
  localparam int LEN_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = 32;
  localparam int RECIP_W     = 32;
  localparam int RECIP_STEPS = 33;
  localparam int STEP_W      = $clog2(RECIP_STEPS + 1);
  localparam int RED_W       = MOD_W + 2;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RING_LEN = 1'b1;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [MOD_W-1:0] MODULUS_RESET  = 16'd2048;
  localparam logic [LEN_W-1:0] RING_LEN_RESET = 10'd512;

  typedef struct packed {
    logic                     req_type;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] a_coef;
    logic signed [COEF_W-1:0] b_coef;
  } item_t;

  typedef struct packed {
    logic [MOD_W-1:0] product_coef;
    logic             error;
  } result_t;

  typedef struct packed {
    logic clr_step;
    logic recip_start;
    logic capture;
    logic push_a;
    logic push_b;
    logic issue;
    logic respond;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic recip_done;
    logic idx_err;
    logic req_read;
    logic issue_last;
    logic pipe_busy;
    logic mod_wr;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/ccmq_recip.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ccmq_recip (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [ccmq_pkg::MOD_W-1:0]   divisor,
  output logic                         done,
  output logic [ccmq_pkg::RECIP_W-1:0] quot
);
  import ccmq_pkg::*;

  logic [MOD_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic [MOD_W:0]    trial;
  logic              fit;

  // dividend is 2^32: one leading one, then zeros
  assign trial = {rem, (cnt == STEP_W'(RECIP_STEPS))};
  assign fit   = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= STEP_W'(RECIP_STEPS);
      end else if (cnt != '0) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quot <= '0;
    end else if (cnt != '0) begin
      rem  <= fit ? MOD_W'(trial - {1'b0, divisor}) : trial[MOD_W-1:0];
      quot <= {quot[RECIP_W-2:0], fit};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ccmq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ccmq_datapath #(
  parameter int MAX_LEN = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ccmq_pkg::item_t                 item,
  input  logic                            cfg_we,
  input  logic [ccmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccmq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  ccmq_pkg::cmd_t                  cmd,
  output ccmq_pkg::status_t               status,
  output ccmq_pkg::result_t               result
);
  import ccmq_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int CW = (LW > LEN_W) ? LW : LEN_W;
  localparam logic SEL_A = 1'b0;
  localparam logic SEL_B = 1'b1;

  logic [MOD_W-1:0]  modulus_r;
  logic [LEN_W-1:0]  ring_len_r;
  logic [LW-1:0]     n_eff;
  logic              q_small;
  logic [RECIP_W-1:0] m_val;
  logic              recip_done;

  logic [IDX_W-1:0]  k_r;
  logic              mode_read;
  logic              err_r;
  logic [COEF_W-1:0] a_r;
  logic [COEF_W-1:0] b_r;
  logic [AW-1:0]     i_cnt;
  logic [AW-1:0]     j_cnt;
  logic [AW-1:0]     clr_addr;

  logic [COEF_W-1:0] a_mem [MAX_LEN];
  logic [COEF_W-1:0] b_mem [MAX_LEN];
  logic [COEF_W-1:0] ra;
  logic [COEF_W-1:0] rb;

  logic              va0, v1, v2, v3, v4;
  logic [PROD_W-1:0] p1, p2;
  logic [RECIP_W-1:0] qh2;
  logic [RED_W-1:0]  r3;
  logic [MOD_W-1:0]  r4;
  logic              neg1, neg2, neg3, neg4;
  logic              sel1, sel2, sel3, sel4;
  logic [MOD_W-1:0]  acc;

  logic [2*PROD_W-1:0] est;
  logic [RED_W+MOD_W-1:0] qq;
  logic [RED_W-1:0]  q_ext;
  logic [MOD_W-1:0]  fixed;
  logic [MOD_W:0]    sum;
  logic [MOD_W-1:0]  acc_next;
  logic [COEF_W-1:0] a_abs;
  logic [COEF_W-1:0] b_abs;

  logic              a_we, b_we;
  logic [AW-1:0]     wa;
  logic [COEF_W-1:0] wd;

  ccmq_recip u_recip (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.recip_start),
    .divisor (modulus_r),
    .done    (recip_done),
    .quot    (m_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus_r  <= MODULUS_RESET;
      ring_len_r <= RING_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS:  modulus_r  <= cfg_data[MOD_W-1:0];
        REG_RING_LEN: ring_len_r <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  always_comb begin
    n_eff   = (CW'(ring_len_r) > CW'(MAX_LEN)) ? LW'(MAX_LEN) : LW'(ring_len_r);
    q_small = modulus_r < MOD_W'(2);
    q_ext   = {2'b00, modulus_r};
    a_abs   = a_r[COEF_W-1] ? COEF_W'(-a_r) : a_r;
    b_abs   = b_r[COEF_W-1] ? COEF_W'(-b_r) : b_r;
    est     = p1 * m_val;
    qq      = qh2[RED_W-1:0] * modulus_r;
    fixed   = q_small ? '0 :
              ((neg4 && (r4 != '0)) ? MOD_W'(modulus_r - r4) : r4);
    sum      = {1'b0, acc} + {1'b0, r4};
    acc_next = (sum >= {1'b0, modulus_r}) ? MOD_W'(sum - {1'b0, modulus_r})
                                          : sum[MOD_W-1:0];
    a_we = cmd.clr_step || (v4 && !mode_read && (sel4 == SEL_A));
    b_we = cmd.clr_step || (v4 && !mode_read && (sel4 == SEL_B));
    wa   = cmd.clr_step ? clr_addr : AW'(k_r);
    wd   = cmd.clr_step ? '0 : fixed;
  end

  always_comb begin
    status.clr_last   = clr_addr == AW'(MAX_LEN - 1);
    status.recip_done = recip_done;
    status.idx_err    = CW'(item.coef_index) >= CW'(n_eff);
    status.req_read   = item.req_type == REQ_READ;
    status.issue_last = LW'(i_cnt) == (n_eff - LW'(1));
    status.pipe_busy  = va0 | v1 | v2 | v3 | v4;
    status.mod_wr     = cfg_we && (cfg_index == REG_MODULUS);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      va0 <= 1'b0;
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      v4  <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_addr <= clr_addr + AW'(1);
      end
      va0 <= cmd.issue;
      v1  <= va0 | cmd.push_a | cmd.push_b;
      v2  <= v1;
      v3  <= v2;
      v4  <= v3;
    end
  end

  // request capture and operand walk
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      k_r       <= item.coef_index;
      mode_read <= item.req_type == REQ_READ;
      err_r     <= status.idx_err;
      a_r       <= item.a_coef;
      b_r       <= item.b_coef;
      i_cnt     <= '0;
      j_cnt     <= AW'(item.coef_index);
      acc       <= '0;
    end else begin
      if (cmd.issue) begin
        i_cnt <= i_cnt + AW'(1);
        j_cnt <= (j_cnt == '0) ? AW'(n_eff - LW'(1)) : j_cnt - AW'(1);
      end
      if (v4 && mode_read) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_we) begin
      a_mem[wa] <= wd;
    end
    if (cmd.issue) begin
      ra <= a_mem[i_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[wa] <= wd;
    end
    if (cmd.issue) begin
      rb <= b_mem[j_cnt];
    end
  end

  // multiply and Barrett reduction
  always_ff @(posedge clk) begin
    if (cmd.push_a) begin
      p1   <= PROD_W'(a_abs);
      neg1 <= a_r[COEF_W-1];
      sel1 <= SEL_A;
    end else if (cmd.push_b) begin
      p1   <= PROD_W'(b_abs);
      neg1 <= b_r[COEF_W-1];
      sel1 <= SEL_B;
    end else begin
      p1   <= PROD_W'(ra) * PROD_W'(rb);
      neg1 <= 1'b0;
      sel1 <= SEL_A;
    end
    p2   <= p1;
    qh2  <= est[2*PROD_W-1:PROD_W];
    neg2 <= neg1;
    sel2 <= sel1;
    r3   <= p2[RED_W-1:0] - qq[RED_W-1:0];
    neg3 <= neg2;
    sel3 <= sel2;
    r4   <= (r3 >= q_ext) ? MOD_W'(r3 - q_ext) : r3[MOD_W-1:0];
    neg4 <= neg3;
    sel4 <= sel3;
  end

  always_ff @(posedge clk) begin
    if (cmd.respond) begin
      result.product_coef <= (err_r || !mode_read || q_small) ? '0 : acc;
      result.error        <= err_r;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ccmq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ccmq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ccmq_pkg::status_t status,
  output ccmq_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done
);
  import ccmq_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RECIP,
    S_LOAD_A,
    S_LOAD_B,
    S_READ,
    S_DRAIN,
    S_RESP
  } state_t;

  state_t state, state_next;
  logic   dirty;

  assign busy = (state != S_IDLE) || dirty;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        priority if (dirty) begin
          cmd.recip_start = 1'b1;
          state_next      = S_RECIP;
        end else if (start) begin
          cmd.capture = 1'b1;
          priority if (status.idx_err) begin
            state_next = S_RESP;
          end else if (status.req_read) begin
            state_next = S_READ;
          end else begin
            state_next = S_LOAD_A;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RECIP: begin
        if (status.recip_done) begin
          state_next = S_IDLE;
        end
      end
      S_LOAD_A: begin
        cmd.push_a = 1'b1;
        state_next = S_LOAD_B;
      end
      S_LOAD_B: begin
        cmd.push_b = 1'b1;
        state_next = S_DRAIN;
      end
      S_READ: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        cmd.respond = 1'b1;
        state_next  = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      dirty <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.respond;
      if (status.mod_wr) begin
        dirty <= 1'b1;
      end else if (cmd.recip_start) begin
        dirty <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cyclic_convolution_mod_q_core.sv -----
// Cyclic convolution in Z_q[x]/(x^n - 1). A load request reduces one signed coefficient of
// each operand into 0..q-1 and stores the pair at the index; a read request returns product
// coefficient k. Requests are taken when start is high and busy is low. Each request gives
// exactly one result, shown for a single cycle with done high; the receiver cannot stall it,
// so capture it on that cycle. An index at or beyond the ring length gives error and 0.
// In a read, one coefficient pair per cycle is read from the operand memories into a single
// multiply and Barrett-reduce pipeline, which then drains. After reset, busy stays high for a
// clearing pass over all MAX_LEN entries and then while the reciprocal of the modulus is formed;
// every write of the modulus register raises busy again while the reciprocal is formed anew.
`timescale 1ns / 1ps
`default_nettype none

module cyclic_convolution_mod_q_core #(
  parameter int MAX_LEN = 512
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  ccmq_pkg::item_t                 item,
  output logic                            busy,
  output logic                            done,
  output ccmq_pkg::result_t               result,
  input  logic                            cfg_we,
  input  logic [ccmq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccmq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ccmq_pkg::*;

  cmd_t    cmd;
  status_t status;

  ccmq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  ccmq_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

`default_nettype wire

// ----- tb/cyclic_convolution_mod_q_core_test.sv -----
`timescale 1ns / 1ps

module cyclic_convolution_mod_q_core_test;
  import ccmq_pkg::*;

  localparam int MAX_LEN = 512;
  localparam int RANDOM_REQUESTS = 950;
  localparam int CYCLE_LIMIT = 3_000_000;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    item_t                 req;
    logic                  fixed;
    result_t               want;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_value;
  } directed_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  item_t                 item = '0;
  logic                  busy;
  logic                  done;
  result_t               result;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [MOD_W-1:0]  q_now = MODULUS_RESET;
  logic [LEN_W-1:0]  n_now = RING_LEN_RESET;
  logic [COEF_W-1:0] a_coef_mem [MAX_LEN];
  logic [COEF_W-1:0] b_coef_mem [MAX_LEN];
  result_t           results_due [$];
  directed_row_t     directed_rows [$];
  int                mismatch_count = 0;
  int unsigned       cycle_count = 0;

  cyclic_convolution_mod_q_core #(
    .MAX_LEN(MAX_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [COEF_W-1:0] reduce_coef(input logic signed [COEF_W-1:0] raw);
    int x;
    int q;
    int r;
    if (q_now < 2) return '0;
    x = raw;
    q = int'(q_now);
    r = x % q;
    if (r < 0) r += q;
    return r[COEF_W-1:0];
  endfunction

  function automatic result_t ring_request_outcome(input item_t req);
    result_t           res;
    int                n;
    int                k;
    int                j;
    longint unsigned   acc;
    longint unsigned   q;
    res = '0;
    n = (int'(n_now) > MAX_LEN) ? MAX_LEN : int'(n_now);
    k = int'(req.coef_index);
    q = longint'(q_now);
    if (k >= n) begin
      res.error = 1'b1;
    end else if (req.req_type == REQ_LOAD) begin
      a_coef_mem[k] = reduce_coef(req.a_coef);
      b_coef_mem[k] = reduce_coef(req.b_coef);
    end else if (q_now >= 2) begin
      acc = 0;
      for (int i = 0; i < n; i++) begin
        j = (k >= i) ? k - i : k + n - i;
        acc = (acc + (longint'(a_coef_mem[i]) * longint'(b_coef_mem[j])) % q) % q;
      end
      res.product_coef = acc[MOD_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [COEF_W-1:0] pick_coef();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'hffff;
      3: return '0;
      4: return COEF_W'($urandom_range(40)) - 16'd20;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  function automatic directed_row_t req_row(input logic kind_read, input int idx,
                                            input logic [COEF_W-1:0] a,
                                            input logic [COEF_W-1:0] b,
                                            input logic fixed,
                                            input logic [MOD_W-1:0] prod,
                                            input logic err);
    directed_row_t row;
    row = '0;
    row.kind = ROW_REQUEST;
    row.req.req_type = kind_read ? REQ_READ : REQ_LOAD;
    row.req.coef_index = IDX_W'(idx);
    row.req.a_coef = a;
    row.req.b_coef = b;
    row.fixed = fixed;
    row.want.product_coef = prod;
    row.want.error = err;
    return row;
  endfunction

  function automatic directed_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] value);
    directed_row_t row;
    row = '0;
    row.kind = ROW_CONFIG;
    row.reg_index = idx;
    row.reg_value = value;
    return row;
  endfunction

  function automatic void add_row(input directed_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic wait_idle();
    do @(posedge clk); while (busy || results_due.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    start <= 1'b0;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MODULUS) q_now = value;
    else n_now = value[LEN_W-1:0];
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_request(input item_t req, input logic fixed, input result_t want);
    result_t outcome;
    start <= 1'b1;
    item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    outcome = ring_request_outcome(req);
    results_due.insert(results_due.size(), fixed ? want : outcome);
  endtask

  always @(posedge clk) begin
    result_t oldest;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $error("result with none due: product_coef %0d, error %0b",
               result.product_coef, result.error);
        mismatch_count++;
      end else begin
        oldest = results_due.pop_front();
        if (result.product_coef !== oldest.product_coef) begin
          $error("product_coef: expected %0d, actual %0d",
                 oldest.product_coef, result.product_coef);
          mismatch_count++;
        end
        if (result.error !== oldest.error) begin
          $error("error: expected %0b, actual %0b", oldest.error, result.error);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    item_t                 req;
    logic [MOD_W-1:0]      q_pick;
    int                    ring_pick;
    int                    span;
    int                    burst;
    int                    pick;
    int                    sent;
    foreach (a_coef_mem[i]) begin
      a_coef_mem[i] = '0;
      b_coef_mem[i] = '0;
    end

    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b1, 511, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b0, 0, 16'h7fff, 16'h8000, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b0, 511, 16'hffff, 16'h0001, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b0, 1, 16'h8000, 16'h7fff, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(req_row(1'b1, 511, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(req_row(1'b1, 1, 16'hffff, 16'hffff, 1'b0, 16'd0, 1'b0));
    add_row(cfg_row(REG_RING_LEN, 16'd7));
    add_row(req_row(1'b0, 7, 16'h0001, 16'h0001, 1'b1, 16'd0, 1'b1));
    add_row(req_row(1'b1, 7, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b1));
    add_row(req_row(1'b1, 511, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b1));
    add_row(req_row(1'b1, 6, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(cfg_row(REG_MODULUS, 16'd0));
    add_row(req_row(1'b0, 2, 16'h0005, 16'h0005, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b1, 2, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b0));
    add_row(cfg_row(REG_MODULUS, 16'd1));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b0));
    add_row(cfg_row(REG_RING_LEN, 16'd0));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b1, 16'd0, 1'b1));
    add_row(req_row(1'b0, 0, 16'h1234, 16'h4321, 1'b1, 16'd0, 1'b1));
    add_row(cfg_row(REG_RING_LEN, 16'd1023));
    add_row(cfg_row(REG_MODULUS, 16'd65535));
    add_row(req_row(1'b0, 511, 16'h8000, 16'h8000, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b1, 511, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(cfg_row(REG_MODULUS, 16'd2));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));
    add_row(cfg_row(REG_RING_LEN, 16'd1));
    add_row(cfg_row(REG_MODULUS, 16'd2048));
    add_row(req_row(1'b0, 0, 16'h0003, 16'hfffb, 1'b1, 16'd0, 1'b0));
    add_row(req_row(1'b1, 0, 16'h0000, 16'h0000, 1'b0, 16'd0, 1'b0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CONFIG)
        write_reg(directed_rows[r].reg_index, directed_rows[r].reg_value);
      else
        send_request(directed_rows[r].req, directed_rows[r].fixed, directed_rows[r].want);
    end

    sent = 0;
    while (sent < RANDOM_REQUESTS) begin
      case ($urandom_range(15))
        0: q_pick = MOD_W'($urandom_range(1));
        1: q_pick = 16'd2;
        2: q_pick = 16'd65535;
        3: q_pick = 16'd3;
        4: q_pick = 16'd2048;
        default: q_pick = MOD_W'($urandom_range(65535, 2));
      endcase
      case ($urandom_range(15))
        0: ring_pick = 0;
        1: ring_pick = MAX_LEN;
        2: ring_pick = $urandom_range(1023, MAX_LEN + 1);
        3: ring_pick = 1;
        4: ring_pick = 2;
        default: ring_pick = $urandom_range(48, 3);
      endcase
      write_reg(REG_MODULUS, q_pick);
      write_reg(REG_RING_LEN, {6'($urandom), 10'(ring_pick)});
      span = (ring_pick > MAX_LEN) ? MAX_LEN : ring_pick;
      burst = $urandom_range(80, 40);
      repeat (burst) begin
        // hold start low now and then, but leave one long stretch without gaps
        if (!(sent >= 300 && sent < 500) && $urandom_range(99) < 10)
          hold_off($urandom_range(6, 1));
        req = '0;
        req.a_coef = pick_coef();
        req.b_coef = pick_coef();
        pick = $urandom_range(99);
        if (span == 0 || pick < 8) begin
          req.req_type = 1'($urandom_range(1));
          if (span < MAX_LEN)
            req.coef_index = IDX_W'($urandom_range(MAX_LEN - 1, span));
          else
            req.coef_index = IDX_W'($urandom_range(MAX_LEN - 1));
        end else begin
          req.req_type = (pick < 55) ? REQ_LOAD : REQ_READ;
          req.coef_index = IDX_W'($urandom_range(span - 1));
        end
        send_request(req, 1'b0, '0);
        sent++;
      end
    end

    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (MAX_LEN + 40) @(posedge clk);
    if (mismatch_count == 0 && results_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ccmq_pkg.sv
rtl/ccmq_recip.sv
rtl/ccmq_datapath.sv
rtl/ccmq_ctrl.sv
rtl/cyclic_convolution_mod_q_core.sv
tb/cyclic_convolution_mod_q_core_test.sv
